>>> hw/rtl/rshf_pkg.sv
// rshf_pkg: shared types, widths and codes of the rectangle segment hit filter
// depends on nothing; imported by rshf_datapath and rect_segment_hit_filter_unit

package rshf_pkg;

    // field widths of the request and result
    localparam int COORD_BITS = 16;
    localparam int INDEX_BITS = 8;
    localparam int CAUSE_BITS = 3;

    // configuration register widths and indexes
    localparam int RPOS_BITS     = 15;
    localparam int RSIZE_BITS    = 14;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [CFG_ADDR_BITS-1:0] REG_RECT_X = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RECT_Y = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RECT_W = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RECT_H = 2'd3;

    // hit cause codes
    localparam logic [CAUSE_BITS-1:0] CAUSE_NONE   = 3'd0;
    localparam logic [CAUSE_BITS-1:0] CAUSE_BOTTOM = 3'd1;
    localparam logic [CAUSE_BITS-1:0] CAUSE_LEFT   = 3'd2;
    localparam logic [CAUSE_BITS-1:0] CAUSE_TOP    = 3'd3;
    localparam logic [CAUSE_BITS-1:0] CAUSE_RIGHT  = 3'd4;
    localparam logic [CAUSE_BITS-1:0] CAUSE_INSIDE = 3'd5;

    // datapath widths: differences, products, cross-product numerators
    localparam int DIFF_BITS = ((COORD_BITS > RPOS_BITS + 1) ? COORD_BITS : RPOS_BITS + 1) + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int NUM_BITS  = PROD_BITS + 1;

    typedef struct packed {
        logic [INDEX_BITS-1:0]        edge_index;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic                         last_edge;
    } t_edge_req;

    typedef struct packed {
        logic [INDEX_BITS-1:0] hit_index;
        logic                  hit;
        logic [CAUSE_BITS-1:0] hit_cause;
        logic                  scan_done;
    } t_hit_rsp;

    // rectangle as held by the configuration registers
    typedef struct packed {
        logic signed [RPOS_BITS-1:0] x0;
        logic signed [RPOS_BITS-1:0] y0;
        logic [RSIZE_BITS-1:0]       w;
        logic [RSIZE_BITS-1:0]       h;
    } t_rect_cfg;

endpackage

>>> hw/rtl/rect_segment_hit_filter_unit.sv
// rect_segment_hit_filter_unit: top level, configuration registers and result register
// depends on rshf_pkg and rshf_datapath

// Tests one graph edge per clock against the configured closed rectangle. A request
// is taken at every clock edge with start high; busy never rises, so edges may stream
// back to back. Each request yields exactly one result, shown on o_result for one
// cycle with o_valid high; the receiver cannot stall it, so it must take results as
// they come. The result is registered in the difference stage, the multiplier stage,
// the numerator stage and the result register, in that order. Write the
// rectangle registers only when no request is in flight.

module rect_segment_hit_filter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  rshf_pkg::t_edge_req                  i_edge,
    output logic                                 o_valid,
    output rshf_pkg::t_hit_rsp                   o_result,
    input  logic                                 i_cfg_we,
    input  logic [rshf_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [rshf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import rshf_pkg::*;

    logic [RPOS_BITS-1:0]  r_rect_x, r_rect_y;
    logic [RSIZE_BITS-1:0] r_rect_w, r_rect_h;
    t_rect_cfg             rect;
    logic                  dp_valid;
    t_hit_rsp              dp_result;
    logic                  r_valid;
    t_hit_rsp              r_result;

    // the pipeline takes a request every cycle
    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_x <= '0;
            r_rect_y <= '0;
            r_rect_w <= '0;
            r_rect_h <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RECT_X: r_rect_x <= i_cfg_data[RPOS_BITS-1:0];
                REG_RECT_Y: r_rect_y <= i_cfg_data[RPOS_BITS-1:0];
                REG_RECT_W: r_rect_w <= i_cfg_data[RSIZE_BITS-1:0];
                REG_RECT_H: r_rect_h <= i_cfg_data[RSIZE_BITS-1:0];
            endcase
        end
    end

    assign rect.x0 = r_rect_x;
    assign rect.y0 = r_rect_y;
    assign rect.w  = r_rect_w;
    assign rect.h  = r_rect_h;

    rshf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_edge   (i_edge),
        .i_rect   (rect),
        .o_valid  (dp_valid),
        .o_result (dp_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= dp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= dp_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // one result for every request, none otherwise
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("request without result");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_valid)
        else $error("result without request");
    a_scan_done_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 (o_result.scan_done == $past(i_edge.last_edge, 4)))
        else $error("scan end mark misaligned");
    a_hit_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.hit == (o_result.hit_cause != CAUSE_NONE)))
        else $error("hit flag disagrees with cause");

endmodule

>>> hw/rtl/rshf_datapath.sv
// rshf_datapath: three-stage crossing and inside test of one edge per clock
// depends on rshf_pkg; the final priority select is combinational on stage three

module rshf_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rshf_pkg::t_edge_req i_edge,
    input  rshf_pkg::t_rect_cfg i_rect,
    output logic               o_valid,
    output rshf_pkg::t_hit_rsp  o_result
);
    import rshf_pkg::*;

    localparam logic signed [DIFF_BITS-1:0] ZERO_D = '0;
    localparam logic signed [NUM_BITS-1:0]  ZERO_N = '0;

    // closed interval test of n against d on d's side, never true for d of zero
    function automatic logic in_closed(input logic signed [NUM_BITS-1:0] n,
                                       input logic signed [NUM_BITS-1:0] d);
        logic res;
        begin
            if (d == ZERO_N) begin
                res = 1'b0;
            end else if (d > ZERO_N) begin
                res = (n >= ZERO_N) && (n <= d);
            end else begin
                res = (n <= ZERO_N) && (n >= d);
            end
            return res;
        end
    endfunction

    // stage one registers: edge direction and offsets to the rectangle corners
    logic                        r1_valid;
    logic [INDEX_BITS-1:0]       r1_idx;
    logic                        r1_last;
    logic signed [DIFF_BITS-1:0] r1_edx, r1_edy, r1_ox0, r1_ox1, r1_oy0, r1_oy1;

    // stage two registers: products and narrow checks
    logic                        r2_valid;
    logic [INDEX_BITS-1:0]       r2_idx;
    logic                        r2_last;
    logic signed [PROD_BITS-1:0] r2_p_edx_oy0, r2_p_edx_oy1, r2_p_edy_ox0, r2_p_edy_ox1;
    logic signed [PROD_BITS-1:0] r2_p_edy_w, r2_p_edx_h;
    logic [3:0]                  r2_nb_ok;
    logic                        r2_inside;

    // stage three registers: numerators and denominators
    logic                        r3_valid;
    logic [INDEX_BITS-1:0]       r3_idx;
    logic                        r3_last;
    logic signed [NUM_BITS-1:0]  r3_na_bl, r3_na_t, r3_na_r, r3_d_bt, r3_d_lr;
    logic [3:0]                  r3_nb_ok;
    logic                        r3_inside;

    logic signed [DIFF_BITS-1:0] w_s, h_s;
    logic [CAUSE_BITS-1:0]       cause;

    assign w_s = DIFF_BITS'(i_rect.w);
    assign h_s = DIFF_BITS'(i_rect.h);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // stage one: differences
    always_ff @(posedge i_clk) begin
        r1_idx  <= i_edge.edge_index;
        r1_last <= i_edge.last_edge;
        r1_edx  <= DIFF_BITS'(i_edge.end_x) - DIFF_BITS'(i_edge.start_x);
        r1_edy  <= DIFF_BITS'(i_edge.end_y) - DIFF_BITS'(i_edge.start_y);
        r1_ox0  <= DIFF_BITS'(i_rect.x0) - DIFF_BITS'(i_edge.start_x);
        r1_oy0  <= DIFF_BITS'(i_rect.y0) - DIFF_BITS'(i_edge.start_y);
        r1_ox1  <= DIFF_BITS'(i_rect.x0) + w_s - DIFF_BITS'(i_edge.start_x);
        r1_oy1  <= DIFF_BITS'(i_rect.y0) + h_s - DIFF_BITS'(i_edge.start_y);
    end

    // stage two: products, second-parameter checks, inside test
    always_ff @(posedge i_clk) begin
        r2_idx       <= r1_idx;
        r2_last      <= r1_last;
        r2_p_edx_oy0 <= PROD_BITS'(r1_edx) * PROD_BITS'(r1_oy0);
        r2_p_edx_oy1 <= PROD_BITS'(r1_edx) * PROD_BITS'(r1_oy1);
        r2_p_edy_ox0 <= PROD_BITS'(r1_edy) * PROD_BITS'(r1_ox0);
        r2_p_edy_ox1 <= PROD_BITS'(r1_edy) * PROD_BITS'(r1_ox1);
        r2_p_edy_w   <= PROD_BITS'(r1_edy) * PROD_BITS'(w_s);
        r2_p_edx_h   <= PROD_BITS'(r1_edx) * PROD_BITS'(h_s);
        // side length cancels out of the second parameter
        r2_nb_ok[0]  <= in_closed(NUM_BITS'(r1_oy0), NUM_BITS'(r1_edy));
        r2_nb_ok[1]  <= in_closed(NUM_BITS'(r1_ox0), NUM_BITS'(r1_edx));
        r2_nb_ok[2]  <= in_closed(NUM_BITS'(r1_oy1), NUM_BITS'(r1_edy));
        r2_nb_ok[3]  <= in_closed(NUM_BITS'(r1_ox1), NUM_BITS'(r1_edx));
        // both endpoints within the closed rectangle
        r2_inside    <= (r1_ox0 <= ZERO_D) && (r1_ox1 >= ZERO_D)
                     && (r1_oy0 <= ZERO_D) && (r1_oy1 >= ZERO_D)
                     && (r1_ox0 <= r1_edx) && (r1_ox1 >= r1_edx)
                     && (r1_oy0 <= r1_edy) && (r1_oy1 >= r1_edy);
    end

    // stage three: first-parameter numerators, bottom and left share one
    always_ff @(posedge i_clk) begin
        r3_idx    <= r2_idx;
        r3_last   <= r2_last;
        r3_na_bl  <= NUM_BITS'(r2_p_edx_oy0) - NUM_BITS'(r2_p_edy_ox0);
        r3_na_t   <= NUM_BITS'(r2_p_edx_oy1) - NUM_BITS'(r2_p_edy_ox0);
        r3_na_r   <= NUM_BITS'(r2_p_edx_oy0) - NUM_BITS'(r2_p_edy_ox1);
        r3_d_bt   <= NUM_BITS'(r2_p_edy_w);
        r3_d_lr   <= ZERO_N - NUM_BITS'(r2_p_edx_h);
        r3_nb_ok  <= r2_nb_ok;
        r3_inside <= r2_inside;
    end

    // first matching cause in side order
    always_comb begin
        priority if (r3_nb_ok[0] && in_closed(r3_na_bl, r3_d_bt)) begin
            cause = CAUSE_BOTTOM;
        end else if (r3_nb_ok[1] && in_closed(r3_na_bl, r3_d_lr)) begin
            cause = CAUSE_LEFT;
        end else if (r3_nb_ok[2] && in_closed(r3_na_t, r3_d_bt)) begin
            cause = CAUSE_TOP;
        end else if (r3_nb_ok[3] && in_closed(r3_na_r, r3_d_lr)) begin
            cause = CAUSE_RIGHT;
        end else if (r3_inside) begin
            cause = CAUSE_INSIDE;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    assign o_valid            = r3_valid;
    assign o_result.hit_index = r3_idx;
    assign o_result.hit       = (cause != CAUSE_NONE);
    assign o_result.hit_cause = cause;
    assign o_result.scan_done = r3_last;

    // a bottom or left crossing needs its denominator to be nonzero
    a_bottom_needs_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && cause == CAUSE_BOTTOM) |-> (r3_d_bt != ZERO_N))
        else $error("bottom crossing with zero denominator");
    a_left_needs_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && cause == CAUSE_LEFT) |-> (r3_d_lr != ZERO_N))
        else $error("left crossing with zero denominator");
    a_inside_flag_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid |=> (r3_inside == $past(r2_inside)))
        else $error("inside flag lost alignment with its edge");

endmodule
